[sv/nrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nrp_pkg
// Shared widths, datapath operation codes, handshake structs and the
// saturating fixed-point helpers of the Numerov radial propagator.
// ---------------------------------------------------------------------------
package nrp_pkg;

   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 20;
   localparam int MESH_W   = 31;
   localparam int CSR_AW   = 1;
   localparam int NUM_W    = 52;
   localparam int ROOT_W   = 26;
   localparam int OP_W     = 5;

   localparam logic [CSR_AW-1:0] REG_ENERGY    = 1'b0;
   localparam logic [CSR_AW-1:0] REG_MESH_STEP = 1'b1;

   // datapath operations issued by the controller
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_MUL_AA   = 5'd2;
   localparam logic [OP_W-1:0] OP_QA       = 5'd3;
   localparam logic [OP_W-1:0] OP_MUL_DD   = 5'd4;
   localparam logic [OP_W-1:0] OP_D2       = 5'd5;
   localparam logic [OP_W-1:0] OP_MUL_GD   = 5'd6;
   localparam logic [OP_W-1:0] OP_G        = 5'd7;
   localparam logic [OP_W-1:0] OP_SQRT     = 5'd8;
   localparam logic [OP_W-1:0] OP_DIV_SEED = 5'd9;
   localparam logic [OP_W-1:0] OP_TW0      = 5'd10;
   localparam logic [OP_W-1:0] OP_C0       = 5'd11;
   localparam logic [OP_W-1:0] OP_TW1      = 5'd12;
   localparam logic [OP_W-1:0] OP_C1       = 5'd13;
   localparam logic [OP_W-1:0] OP_TW2      = 5'd14;
   localparam logic [OP_W-1:0] OP_C2       = 5'd15;
   localparam logic [OP_W-1:0] OP_MUL_P1   = 5'd16;
   localparam logic [OP_W-1:0] OP_P1       = 5'd17;
   localparam logic [OP_W-1:0] OP_MUL_P2   = 5'd18;
   localparam logic [OP_W-1:0] OP_P2       = 5'd19;
   localparam logic [OP_W-1:0] OP_NUM      = 5'd20;
   localparam logic [OP_W-1:0] OP_DIV_W    = 5'd21;
   localparam logic [OP_W-1:0] OP_WAVE     = 5'd22;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic is_seed;
      logic sqrt_done;
      logic div_done;
      logic out_free;
   } status_type;

   localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

   // magnitude of a signed word
   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
      mag32 = x[DATA_W-1] ? (~x + 32'd1) : x;
   endfunction

   // clamp a sign and magnitude to the signed range: {clamped, value}
   function automatic logic [DATA_W:0] sat_mag_f(input logic neg, input logic [63:0] m);
      if (neg) begin
         if (m > 64'h0000_0000_8000_0000) sat_mag_f = {1'b1, VAL_MIN};
         else sat_mag_f = {1'b0, 32'd0 - m[DATA_W-1:0]};
      end else begin
         if (m > 64'h0000_0000_7fff_ffff) sat_mag_f = {1'b1, VAL_MAX};
         else sat_mag_f = {1'b0, m[DATA_W-1:0]};
      end
   endfunction

   // clamp a widened signed sum to the signed range: {clamped, value}
   function automatic logic [DATA_W:0] sat_s34_f(input logic signed [DATA_W+1:0] x);
      if (x > 34'sh0_7fff_ffff) sat_s34_f = {1'b1, VAL_MAX};
      else if (x < -34'sh0_8000_0000) sat_s34_f = {1'b1, VAL_MIN};
      else sat_s34_f = {1'b0, x[DATA_W-1:0]};
   endfunction

   function automatic logic signed [DATA_W+1:0] sx34(input logic [DATA_W-1:0] x);
      sx34 = signed'({{2{x[DATA_W-1]}}, x});
   endfunction

endpackage : nrp_pkg
`default_nettype wire

[sv/nrp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nrp_div
// Restoring divider, one quotient bit per cycle over a 52-bit numerator,
// with optional round-to-nearest (ties up) on the final remainder.
// ---------------------------------------------------------------------------
module nrp_div import nrp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DATA_W-1:0] den,
   input  wire logic              rnd,
   output logic                   done,
   output logic [NUM_W:0]         quot
);

   logic [NUM_W-1:0]  work_ff, work_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff;
   logic              rnd_ff;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   rem_sh;
   logic              ge;
   logic              bump;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, work_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_in  = rem_ff;
      work_in = work_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         work_in = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? DATA_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DATA_W-1:0];
         work_in = {work_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= den;
         rnd_ff <= rnd;
      end
   end

   // round up when twice the remainder reaches the divisor
   assign bump = rnd_ff && ({rem_ff, 1'b0} >= {1'b0, den_ff});
   assign quot = {1'b0, work_ff} + {{NUM_W{1'b0}}, bump};
   assign done = done_ff;

endmodule : nrp_div
`default_nettype wire

[sv/nrp_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nrp_sqrt
// Digit-by-digit integer square root, one root bit per cycle, truncating.
// ---------------------------------------------------------------------------
module nrp_sqrt import nrp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  radicand,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   logic [NUM_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W+1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W+3:0] rem_sh;
   logic [ROOT_W+3:0] trial;
   logic              ge;

   // bring down two radicand bits, try the next root bit
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[NUM_W-1:NUM_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[NUM_W-3:0], 2'b00};
         rem_in  = ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule : nrp_sqrt
`default_nettype wire

[sv/nrp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nrp_datapath
// Operand registers, the shared multiplier, the divider and root units,
// the recurrence history and the result register of the propagator.
// ---------------------------------------------------------------------------
module nrp_datapath import nrp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [DATA_W-1:0] csr_wdata,
   input  wire logic [MESH_W-1:0] mesh_derivative,
   input  wire logic [DATA_W-1:0] potential,
   input  wire logic [DATA_W-1:0] seed_value,
   input  wire logic              is_seed,
   input  wire logic              last_point,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DATA_W-1:0]      wave_value,
   output logic                   saturated,
   output logic                   last
);

   localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_W;
   // ceil(2^33 / 3): (m * RECIP3) >> 33 is floor(m / 3) for any 32-bit m
   localparam logic [DATA_W-1:0] RECIP3 = 32'haaaa_aaab;

   // configuration
   logic [DATA_W-1:0] energy_ff;
   logic [MESH_W-1:0] mesh_step_ff;

   // per-item operands and intermediates
   logic [MESH_W-1:0] drx_ff;
   logic [DATA_W-1:0] diff_ff, seed_ff, qas_ff, d2_ff, g_ff;
   logic [DATA_W-1:0] c0_ff, c1_ff, c2_ff, p1_ff, p2_ff, num_ff;
   logic              seed_flag_ff, last_flag_ff, sat_ff;
   logic              msign_ff, qneg_ff, numneg_ff, divz_ff;
   logic [63:0]       prod_ff;

   // history
   logic [DATA_W-1:0] v1_ff, v2_ff, g1_ff, g2_ff;

   // result register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] wave_out_ff;
   logic              sat_out_ff, last_out_ff;

   // combinational
   logic [DATA_W-1:0] mul_a, mul_b;
   logic [63:0]       mul_p;
   logic [DATA_W+1:0] tw_n;
   logic [63:0]       rnd20, rnd22;
   logic [DATA_W:0]   mulq, qa_s, d2_s, g_s, t_s, tw_s, c_s, a2_s, n_s, diff_s, wave_s;
   logic              div_start, sqrt_start, div_rnd, div_done, sqrt_done;
   logic [NUM_W-1:0]  div_num;
   logic [DATA_W-1:0] div_den;
   logic [NUM_W:0]    quot;
   logic [ROOT_W-1:0] root;
   logic [DATA_W+2:0] g1_x5;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         mesh_step_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ENERGY:    energy_ff    <= csr_wdata;
            REG_MESH_STEP: mesh_step_ff <= csr_wdata[MESH_W-1:0];
            default: ;
         endcase
      end
   end

   // select multiplier operands; a twelfth is (n / 4) / 3 by reciprocal
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      tw_n  = '0;
      case (cmd.op)
         OP_MUL_AA: begin
            mul_a = {1'b0, mesh_step_ff};
            mul_b = {1'b0, mesh_step_ff};
         end
         OP_MUL_DD: begin
            mul_a = {1'b0, drx_ff};
            mul_b = {1'b0, drx_ff};
         end
         OP_MUL_GD: begin
            mul_a = d2_ff;
            mul_b = mag32(diff_ff);
         end
         OP_MUL_P1: begin
            mul_a = mag32(v1_ff);
            mul_b = mag32(c1_ff);
         end
         OP_MUL_P2: begin
            mul_a = mag32(v2_ff);
            mul_b = mag32(c2_ff);
         end
         OP_TW0: begin
            tw_n  = (DATA_W+2)'(mag32(g_ff)) + (DATA_W+2)'(6);
            mul_a = tw_n[DATA_W+1:2];
            mul_b = RECIP3;
         end
         OP_TW1: begin
            tw_n  = (DATA_W+2)'(g1_x5) + (DATA_W+2)'(6);
            mul_a = tw_n[DATA_W+1:2];
            mul_b = RECIP3;
         end
         OP_TW2: begin
            tw_n  = (DATA_W+2)'(mag32(g2_ff)) + (DATA_W+2)'(6);
            mul_a = tw_n[DATA_W+1:2];
            mul_b = RECIP3;
         end
         default: ;
      endcase
   end

   // rounding, clamping and sums
   always_comb begin
      mul_p  = 64'(mul_a) * 64'(mul_b);
      rnd20  = (prod_ff + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      rnd22  = (prod_ff + (64'd1 << (FRAC_W + 1))) >> (FRAC_W + 2);
      mulq   = sat_mag_f(msign_ff, rnd20);
      qa_s   = sat_mag_f(1'b0, rnd22);
      d2_s   = sat_mag_f(1'b0, rnd20);
      g_s    = sat_s34_f(sx34(mulq[DATA_W-1:0]) - sx34(qas_ff));
      t_s    = sat_mag_f(qneg_ff, {{(63 - NUM_W){1'b0}}, quot});
      tw_s   = sat_mag_f(qneg_ff, {33'd0, prod_ff[63:33]});
      diff_s = sat_s34_f(sx34(energy_ff) - sx34(potential));
      a2_s   = sat_s34_f(sx34(p1_ff) + sx34(p1_ff));
      n_s    = sat_s34_f(sx34(a2_s[DATA_W-1:0]) - sx34(p2_ff));
      c_s    = sat_s34_f(sx34(ONE) + sx34(tw_s[DATA_W-1:0]));
      if (cmd.op == OP_C1) c_s = sat_s34_f(sx34(ONE) - sx34(tw_s[DATA_W-1:0]));
      if (divz_ff) wave_s = {1'b1, numneg_ff ? VAL_MIN : VAL_MAX};
      else wave_s = t_s;
      g1_x5  = {1'b0, mag32(g1_ff), 2'b00} + {3'b000, mag32(g1_ff)};
   end

   // divider and root unit requests
   always_comb begin
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      div_rnd    = 1'b0;
      div_num    = '0;
      div_den    = '0;
      case (cmd.op)
         OP_SQRT: sqrt_start = 1'b1;
         OP_DIV_SEED: begin
            div_start = 1'b1;
            div_rnd   = 1'b1;
            div_num   = {mag32(seed_ff), {FRAC_W{1'b0}}};
            div_den   = {{(DATA_W - ROOT_W){1'b0}}, root};
         end
         OP_DIV_W: begin
            div_start = 1'b1;
            div_rnd   = 1'b1;
            div_num   = {mag32(num_ff), {FRAC_W{1'b0}}};
            div_den   = mag32(c0_ff);
         end
         default: ;
      endcase
   end

   nrp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rnd   (div_rnd),
      .done  (div_done),
      .quot  (quot)
   );

   nrp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, drx_ff, {FRAC_W{1'b0}}}),
      .done     (sqrt_done),
      .root     (root)
   );

   // operand and intermediate registers
   always_ff @(posedge clock) begin
      case (cmd.op) inside
         OP_LOAD: begin
            drx_ff       <= mesh_derivative;
            seed_ff      <= seed_value;
            seed_flag_ff <= is_seed;
            last_flag_ff <= last_point;
            diff_ff      <= diff_s[DATA_W-1:0];
            sat_ff       <= diff_s[DATA_W];
         end
         OP_MUL_AA, OP_MUL_DD: prod_ff <= mul_p;
         OP_MUL_GD: begin
            prod_ff  <= mul_p;
            msign_ff <= diff_ff[DATA_W-1];
         end
         OP_MUL_P1: begin
            prod_ff  <= mul_p;
            msign_ff <= v1_ff[DATA_W-1] ^ c1_ff[DATA_W-1];
         end
         OP_MUL_P2: begin
            prod_ff  <= mul_p;
            msign_ff <= v2_ff[DATA_W-1] ^ c2_ff[DATA_W-1];
         end
         OP_QA: begin
            qas_ff <= qa_s[DATA_W-1:0];
            sat_ff <= sat_ff | qa_s[DATA_W];
         end
         OP_D2: begin
            d2_ff  <= d2_s[DATA_W-1:0];
            sat_ff <= sat_ff | d2_s[DATA_W];
         end
         OP_G: begin
            g_ff   <= g_s[DATA_W-1:0];
            sat_ff <= sat_ff | mulq[DATA_W] | g_s[DATA_W];
         end
         OP_DIV_SEED: begin
            qneg_ff   <= seed_ff[DATA_W-1];
            numneg_ff <= seed_ff[DATA_W-1];
            divz_ff   <= (root == '0);
         end
         OP_TW0: begin
            prod_ff <= mul_p;
            qneg_ff <= g_ff[DATA_W-1];
         end
         OP_TW1: begin
            prod_ff <= mul_p;
            qneg_ff <= g1_ff[DATA_W-1];
         end
         OP_TW2: begin
            prod_ff <= mul_p;
            qneg_ff <= g2_ff[DATA_W-1];
         end
         OP_C0: begin
            c0_ff  <= c_s[DATA_W-1:0];
            sat_ff <= sat_ff | tw_s[DATA_W] | c_s[DATA_W];
         end
         OP_C1: begin
            c1_ff  <= c_s[DATA_W-1:0];
            sat_ff <= sat_ff | tw_s[DATA_W] | c_s[DATA_W];
         end
         OP_C2: begin
            c2_ff  <= c_s[DATA_W-1:0];
            sat_ff <= sat_ff | tw_s[DATA_W] | c_s[DATA_W];
         end
         OP_P1: begin
            p1_ff  <= mulq[DATA_W-1:0];
            sat_ff <= sat_ff | mulq[DATA_W];
         end
         OP_P2: begin
            p2_ff  <= mulq[DATA_W-1:0];
            sat_ff <= sat_ff | mulq[DATA_W];
         end
         OP_NUM: begin
            num_ff <= n_s[DATA_W-1:0];
            sat_ff <= sat_ff | a2_s[DATA_W] | n_s[DATA_W];
         end
         OP_DIV_W: begin
            qneg_ff   <= num_ff[DATA_W-1] ^ c0_ff[DATA_W-1];
            numneg_ff <= num_ff[DATA_W-1];
            divz_ff   <= (c0_ff == '0);
         end
         default: ;
      endcase
   end

   // advance history and load the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= '0;
         v2_ff        <= '0;
         g1_ff        <= '0;
         g2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_WAVE) begin
         v1_ff        <= wave_s[DATA_W-1:0];
         v2_ff        <= v1_ff;
         g1_ff        <= g_ff;
         g2_ff        <= g1_ff;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_WAVE) begin
         wave_out_ff <= wave_s[DATA_W-1:0];
         sat_out_ff  <= sat_ff | wave_s[DATA_W];
         last_out_ff <= last_flag_ff;
      end
   end

   assign status.is_seed   = seed_flag_ff;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign wave_value = wave_out_ff;
   assign saturated  = sat_out_ff;
   assign last       = last_out_ff;

endmodule : nrp_datapath
`default_nettype wire

[sv/nrp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nrp_ctrl
// Sequencer of the propagator: steps the datapath through the g term, then
// either the seed root and divide or the three-term recurrence.
// ---------------------------------------------------------------------------
module nrp_ctrl import nrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MAA   = 5'd1;
   localparam logic [4:0] ST_QA    = 5'd2;
   localparam logic [4:0] ST_MDD   = 5'd3;
   localparam logic [4:0] ST_D2    = 5'd4;
   localparam logic [4:0] ST_MGD   = 5'd5;
   localparam logic [4:0] ST_G     = 5'd6;
   localparam logic [4:0] ST_SQ_GO = 5'd7;
   localparam logic [4:0] ST_SQ_W  = 5'd8;
   localparam logic [4:0] ST_DS_GO = 5'd9;
   localparam logic [4:0] ST_DS_W  = 5'd10;
   localparam logic [4:0] ST_T0    = 5'd11;
   localparam logic [4:0] ST_C0    = 5'd13;
   localparam logic [4:0] ST_T1    = 5'd14;
   localparam logic [4:0] ST_C1    = 5'd16;
   localparam logic [4:0] ST_T2    = 5'd17;
   localparam logic [4:0] ST_C2    = 5'd19;
   localparam logic [4:0] ST_MP1   = 5'd20;
   localparam logic [4:0] ST_P1    = 5'd21;
   localparam logic [4:0] ST_MP2   = 5'd22;
   localparam logic [4:0] ST_P2    = 5'd23;
   localparam logic [4:0] ST_NUM   = 5'd24;
   localparam logic [4:0] ST_DW_GO = 5'd25;
   localparam logic [4:0] ST_DW_W  = 5'd26;
   localparam logic [4:0] ST_OUT   = 5'd27;

   logic [4:0] state_ff, state_in;

   // next state and issued operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = ST_MAA;
         end
         ST_MAA: begin cmd.op = OP_MUL_AA; state_in = ST_QA;  end
         ST_QA:  begin cmd.op = OP_QA;     state_in = ST_MDD; end
         ST_MDD: begin cmd.op = OP_MUL_DD; state_in = ST_D2;  end
         ST_D2:  begin cmd.op = OP_D2;     state_in = ST_MGD; end
         ST_MGD: begin cmd.op = OP_MUL_GD; state_in = ST_G;   end
         ST_G: begin
            cmd.op   = OP_G;
            state_in = status.is_seed ? ST_SQ_GO : ST_T0;
         end
         ST_SQ_GO: begin cmd.op = OP_SQRT; state_in = ST_SQ_W; end
         ST_SQ_W: if (status.sqrt_done) state_in = ST_DS_GO;
         ST_DS_GO: begin cmd.op = OP_DIV_SEED; state_in = ST_DS_W; end
         ST_DS_W: if (status.div_done) state_in = ST_OUT;
         ST_T0:    begin cmd.op = OP_TW0;    state_in = ST_C0;  end
         ST_C0:    begin cmd.op = OP_C0;     state_in = ST_T1;  end
         ST_T1:    begin cmd.op = OP_TW1;    state_in = ST_C1;  end
         ST_C1:    begin cmd.op = OP_C1;     state_in = ST_T2;  end
         ST_T2:    begin cmd.op = OP_TW2;    state_in = ST_C2;  end
         ST_C2:    begin cmd.op = OP_C2;     state_in = ST_MP1; end
         ST_MP1:   begin cmd.op = OP_MUL_P1; state_in = ST_P1;  end
         ST_P1:    begin cmd.op = OP_P1;     state_in = ST_MP2; end
         ST_MP2:   begin cmd.op = OP_MUL_P2; state_in = ST_P2;  end
         ST_P2:    begin cmd.op = OP_P2;     state_in = ST_NUM; end
         ST_NUM:   begin cmd.op = OP_NUM;    state_in = ST_DW_GO; end
         ST_DW_GO: begin cmd.op = OP_DIV_W;  state_in = ST_DW_W;  end
         ST_DW_W: if (status.div_done) state_in = ST_OUT;
         // hold until the result register is free
         ST_OUT: if (status.out_free) begin
            cmd.op   = OP_WAVE;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule : nrp_ctrl
`default_nettype wire

[sv/numerov_radial_propagator.sv]
`timescale 1ns / 1ps
`default_nettype none
// One word is worked at a time: a new word is accepted only after the result
// of the previous one is loaded into the result register, and a result word
// still waiting on the output holds the sequencer. Each point runs the 52-step
// divider once; a seed point also runs the 26-step root unit before it.
// Reset (synchronous) clears the history, the configuration and the handshake.
// ---------------------------------------------------------------------------
// numerov_radial_propagator
// Numerov propagation of the radial equation on a logarithmic mesh.
// ---------------------------------------------------------------------------
module numerov_radial_propagator import nrp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [30:0] mesh_derivative, [62:31] potential, [94:63] seed_value, [95] zero
   input  wire logic [95:0]       req_tdata,
   // [0] is_seed
   input  wire logic              req_tuser,
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [31:0] wave_value
   output logic [DATA_W-1:0]      rsp_tdata,
   // [0] saturated
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   nrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   nrp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mesh_derivative (req_tdata[30:0]),
      .potential       (req_tdata[62:31]),
      .seed_value      (req_tdata[94:63]),
      .is_seed         (req_tuser),
      .last_point      (req_tlast),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .wave_value      (rsp_tdata),
      .saturated       (rsp_tuser),
      .last            (rsp_tlast)
   );

   // one word in flight: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // a finished word always shows on the result side
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_WAVE |=> rsp_tvalid)
      else $error("result word not presented");

   // never overwrite a result word that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_WAVE |-> !rsp_tvalid || rsp_tready)
      else $error("result word overwritten");

   // the sequencer is idle right after reset
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("not idle after reset");

endmodule : numerov_radial_propagator
`default_nettype wire
